// ===== rtl/tag_pkg.sv =====
`default_nettype none

package tag_pkg;

    // tile storage defaults
    localparam int TILE_COUNT_DEF = 8;
    localparam int QUEUE_DEPTH    = 2;

    // texture memory addressing
    localparam int TMEM_ADDR_BITS = 12;
    localparam logic [11:0] ADDR_MASK      = 12'hfff;
    localparam logic [11:0] ADDR_MASK_HALF = 12'hffe;
    localparam logic [11:0] ADDR_MASK_WORD = 12'hffc;
    localparam logic [8:0]  LINE_MASK      = 9'h1ff;
    localparam int          PALETTE_AREA   = 'h100;
    localparam logic [11:0] PAL_BASE       = 12'((PALETTE_AREA * 8) & 'hfff);

    // whole-texel coordinate width kept after the fraction is dropped
    localparam int COORD_W = 13;

    // input actions
    localparam logic [1:0] ACT_SET_TILE = 2'd0;
    localparam logic [1:0] ACT_SET_SIZE = 2'd1;
    localparam logic [1:0] ACT_SAMPLE   = 2'd2;

    // queue operation codes
    localparam logic [1:0] OP_SET_TILE = 2'd0;
    localparam logic [1:0] OP_SET_SIZE = 2'd1;
    localparam logic [1:0] OP_SAMPLE   = 2'd2;
    localparam logic [1:0] OP_NO_TILE  = 2'd3;

    // size codes
    localparam logic [1:0] SIZE_4  = 2'd0;
    localparam logic [1:0] SIZE_8  = 2'd1;
    localparam logic [1:0] SIZE_16 = 2'd2;
    localparam logic [1:0] SIZE_32 = 2'd3;

    // format code for color index
    localparam logic [2:0] FMT_INDEX = 3'd2;

    // texel kinds
    localparam logic [2:0] KIND_16     = 3'd0;
    localparam logic [2:0] KIND_32     = 3'd1;
    localparam logic [2:0] KIND_INDEX8 = 3'd2;
    localparam logic [2:0] KIND_INTENS = 3'd3;
    localparam logic [2:0] KIND_INDEX4 = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         tile;
        logic [8:0]         base;
        logic [9:0]         line;
        logic [3:0]         palette;
        logic [2:0]         format;
        logic [1:0]         size_code;
        logic [3:0]         mask_s;
        logic [3:0]         mask_t;
        logic [11:0]        origin_s;
        logic [11:0]        origin_t;
        logic [COORD_W-1:0] s_whole;
        logic [COORD_W-1:0] t_whole;
    } tag_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tag_queue_status_t;

    // keep the low m bits when m is nonzero
    function automatic logic [COORD_W-1:0] apply_mask(input logic [COORD_W-1:0] v,
                                                      input logic [3:0] m);
        logic [COORD_W-1:0] keep;
        if (m == 4'd0 || 32'(m) >= COORD_W)
            keep = '1;
        else
            keep = ~({COORD_W{1'b1}} << m);
        return v & keep;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/texel_address_generator_core.sv =====
// a sample result passes the queue and back-end stages a, b and c before it strobes
// throughput: one transaction per cycle; the back end drains the queue every cycle
// busy rises only when the two-entry queue between front and back is full
// results leave on a one-cycle strobe; the receiver cannot stall
// reset (async, active low): tile table cleared to zero, queue empty, no strobe
`default_nettype none

module texel_address_generator_core #(
    parameter int TILE_COUNT = tag_pkg::TILE_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request transaction
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         action,
    input  wire logic [63:0]        command_word,
    input  wire logic [2:0]         tile_index,
    input  wire logic signed [31:0] s_coord,
    input  wire logic signed [31:0] t_coord,
    // result transaction
    output logic                    result_strobe,
    output logic [11:0]             texel_address,
    output logic [2:0]              texel_kind,
    output logic                    nibble_high,
    output logic [11:0]             palette_base,
    output logic                    no_texel
);

    tag_pkg::tag_entry_t        front_entry;
    tag_pkg::tag_entry_t        head;
    tag_pkg::tag_queue_status_t q_status;
    logic                       front_push;
    logic                       accept;

    // a transaction is taken whenever the queue has room
    assign busy   = q_status.full;
    assign accept = start && !busy;

    // front end: decode the command word, check the tile number, drop
    // unused actions and out-of-range tile writes
    tag_front #(
        .TILE_COUNT (TILE_COUNT)
    ) u_front (
        .sel          (accept),
        .action       (action),
        .command_word (command_word),
        .tile_index   (tile_index),
        .s_coord      (s_coord),
        .t_coord      (t_coord),
        .push         (front_push),
        .entry        (front_entry)
    );

    // short queue so front and back stall independently; keeps order so
    // tile writes land before any later sample reads them
    tag_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_entry (front_entry),
        .pop        (!q_status.empty),
        .head       (head),
        .status     (q_status)
    );

    // back end: tile table updates at pop, sample pipeline of three
    // register stages (mask, row multiply, kind select)
    tag_back #(
        .TILE_COUNT (TILE_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (!q_status.empty),
        .head          (head),
        .result_strobe (result_strobe),
        .texel_address (texel_address),
        .texel_kind    (texel_kind),
        .nibble_high   (nibble_high),
        .palette_base  (palette_base),
        .no_texel      (no_texel)
    );

endmodule

`default_nettype wire

// ===== rtl/tag_front.sv =====
`default_nettype none

module tag_front #(
    parameter int TILE_COUNT = tag_pkg::TILE_COUNT_DEF
) (
    input  wire logic                sel,
    input  wire logic [1:0]          action,
    input  wire logic [63:0]         command_word,
    input  wire logic [2:0]          tile_index,
    input  wire logic signed [31:0]  s_coord,
    input  wire logic signed [31:0]  t_coord,
    output logic                     push,
    output tag_pkg::tag_entry_t      entry
);

    logic [2:0] cmd_tile;
    logic       cmd_tile_ok;
    logic       smp_tile_ok;
    logic [8:0] raw_line;

    assign cmd_tile    = command_word[26:24];
    assign cmd_tile_ok = int'(cmd_tile) < TILE_COUNT;
    assign smp_tile_ok = int'(tile_index) < TILE_COUNT;
    assign raw_line    = command_word[49:41] & tag_pkg::LINE_MASK;

    always_comb
    begin
        entry           = '0;
        push            = 1'b0;
        entry.base      = command_word[40:32];
        entry.palette   = command_word[23:20];
        entry.format    = command_word[55:53];
        entry.size_code = command_word[52:51];
        entry.mask_t    = command_word[17:14];
        entry.mask_s    = command_word[7:4];
        entry.origin_s  = command_word[55:44];
        entry.origin_t  = command_word[43:32];
        entry.s_whole   = s_coord[tag_pkg::COORD_W+9:10];
        entry.t_whole   = t_coord[tag_pkg::COORD_W+9:10];
        // 32-bit tiles count line in half-words of the stored unit
        if (command_word[52:51] == tag_pkg::SIZE_32)
            entry.line = {raw_line, 1'b0};
        else
            entry.line = {1'b0, raw_line};
        case (action)
            tag_pkg::ACT_SET_TILE:
            begin
                entry.op   = tag_pkg::OP_SET_TILE;
                entry.tile = cmd_tile;
                push       = sel && cmd_tile_ok;
            end
            tag_pkg::ACT_SET_SIZE:
            begin
                entry.op   = tag_pkg::OP_SET_SIZE;
                entry.tile = cmd_tile;
                push       = sel && cmd_tile_ok;
            end
            tag_pkg::ACT_SAMPLE:
            begin
                entry.op   = smp_tile_ok ? tag_pkg::OP_SAMPLE : tag_pkg::OP_NO_TILE;
                entry.tile = tile_index;
                push       = sel;
            end
            default:
            begin
                entry.op   = tag_pkg::OP_NO_TILE;
                entry.tile = tile_index;
                push       = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tag_queue.sv =====
`default_nettype none

module tag_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire tag_pkg::tag_entry_t    push_entry,
    input  wire logic                   pop,
    output tag_pkg::tag_entry_t         head,
    output tag_pkg::tag_queue_status_t  status
);

    localparam int PTR_W = (tag_pkg::QUEUE_DEPTH > 1) ? $clog2(tag_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tag_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tag_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(tag_pkg::QUEUE_DEPTH);

    tag_pkg::tag_entry_t slot_reg [tag_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// ===== rtl/tag_back.sv =====
`default_nettype none

module tag_back #(
    parameter int TILE_COUNT = tag_pkg::TILE_COUNT_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  wire tag_pkg::tag_entry_t head,
    output logic                     result_strobe,
    output logic [11:0]              texel_address,
    output logic [2:0]               texel_kind,
    output logic                     nibble_high,
    output logic [11:0]              palette_base,
    output logic                     no_texel
);

    localparam int TIDX_W = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
    localparam int CW     = tag_pkg::COORD_W;

    // tile descriptor table
    logic [8:0]  base_reg     [TILE_COUNT];
    logic [9:0]  line_reg     [TILE_COUNT];
    logic [3:0]  palette_reg  [TILE_COUNT];
    logic [2:0]  format_reg   [TILE_COUNT];
    logic [1:0]  size_reg     [TILE_COUNT];
    logic [3:0]  mask_s_reg   [TILE_COUNT];
    logic [3:0]  mask_t_reg   [TILE_COUNT];
    logic [11:0] origin_s_reg [TILE_COUNT];
    logic [11:0] origin_t_reg [TILE_COUNT];

    logic [TIDX_W-1:0] idx;
    logic              wr_tile;
    logic              wr_size;
    logic              is_sample;
    logic [CW-1:0]     s_next;
    logic [CW-1:0]     t_next;

    // stage a: origin subtracted and masked
    logic          a_valid_reg;
    logic          a_none_reg;
    logic [CW-1:0] a_s_reg;
    logic [8:0]    a_t_reg;
    logic [8:0]    a_base_reg;
    logic [9:0]    a_line_reg;
    logic [3:0]    a_pal_reg;
    logic [2:0]    a_fmt_reg;
    logic [1:0]    a_size_reg;

    // stage b: row address
    logic          b_valid_reg;
    logic          b_none_reg;
    logic [CW-1:0] b_s_reg;
    logic [11:0]   b_row_reg;
    logic [3:0]    b_pal_reg;
    logic [2:0]    b_fmt_reg;
    logic [1:0]    b_size_reg;
    logic [18:0]   product;
    logic [11:0]   row_next;

    // stage c: result
    logic        strobe_reg;
    logic [11:0] addr_reg, addr_next;
    logic [2:0]  kind_reg, kind_next;
    logic        nib_reg, nib_next;
    logic [11:0] pal_reg, pal_next;
    logic        none_reg, none_next;

    assign idx       = head.tile[TIDX_W-1:0];
    assign wr_tile   = head_valid && (head.op == tag_pkg::OP_SET_TILE);
    assign wr_size   = head_valid && (head.op == tag_pkg::OP_SET_SIZE);
    assign is_sample = head_valid &&
                       (head.op == tag_pkg::OP_SAMPLE || head.op == tag_pkg::OP_NO_TILE);

    assign s_next = tag_pkg::apply_mask(head.s_whole - {3'b0, origin_s_reg[idx][11:2]},
                                        mask_s_reg[idx]);
    assign t_next = tag_pkg::apply_mask(head.t_whole - {3'b0, origin_t_reg[idx][11:2]},
                                        mask_t_reg[idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TILE_COUNT; i++)
            begin
                base_reg[i]     <= '0;
                line_reg[i]     <= '0;
                palette_reg[i]  <= '0;
                format_reg[i]   <= '0;
                size_reg[i]     <= '0;
                mask_s_reg[i]   <= '0;
                mask_t_reg[i]   <= '0;
                origin_s_reg[i] <= '0;
                origin_t_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr_tile)
            begin
                base_reg[idx]    <= head.base;
                line_reg[idx]    <= head.line;
                palette_reg[idx] <= head.palette;
                format_reg[idx]  <= head.format;
                size_reg[idx]    <= head.size_code;
                mask_s_reg[idx]  <= head.mask_s;
                mask_t_reg[idx]  <= head.mask_t;
            end
            if (wr_size)
            begin
                origin_s_reg[idx] <= head.origin_s;
                origin_t_reg[idx] <= head.origin_t;
            end
        end
    end

    // only low 9 bits of t times line survive the wrap after the times-8
    assign product  = a_t_reg * a_line_reg;
    assign row_next = {a_base_reg, 3'b0} + {product[8:0], 3'b0};

    always_comb
    begin
        addr_next = '0;
        kind_next = tag_pkg::KIND_16;
        nib_next  = 1'b0;
        pal_next  = '0;
        none_next = 1'b0;
        if (b_none_reg)
            none_next = 1'b1;
        else
        begin
            case (b_size_reg)
                tag_pkg::SIZE_16:
                begin
                    kind_next = tag_pkg::KIND_16;
                    addr_next = (b_row_reg + {b_s_reg[10:0], 1'b0}) & tag_pkg::ADDR_MASK_HALF;
                end
                tag_pkg::SIZE_32:
                begin
                    kind_next = tag_pkg::KIND_32;
                    addr_next = (b_row_reg + {b_s_reg[9:0], 2'b0}) & tag_pkg::ADDR_MASK_WORD;
                end
                tag_pkg::SIZE_8:
                begin
                    addr_next = (b_row_reg + b_s_reg[11:0]) & tag_pkg::ADDR_MASK;
                    if (b_fmt_reg == tag_pkg::FMT_INDEX)
                    begin
                        kind_next = tag_pkg::KIND_INDEX8;
                        pal_next  = tag_pkg::PAL_BASE;
                    end
                    else
                        kind_next = tag_pkg::KIND_INTENS;
                end
                default:
                begin
                    if (b_fmt_reg == tag_pkg::FMT_INDEX)
                    begin
                        kind_next = tag_pkg::KIND_INDEX4;
                        addr_next = (b_row_reg + b_s_reg[12:1]) & tag_pkg::ADDR_MASK;
                        nib_next  = b_s_reg[0];
                        pal_next  = tag_pkg::PAL_BASE + {1'b0, b_pal_reg, 7'b0};
                    end
                    else
                        none_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            a_valid_reg <= is_sample;
            b_valid_reg <= a_valid_reg;
            strobe_reg  <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_none_reg <= (head.op == tag_pkg::OP_NO_TILE);
        a_s_reg    <= s_next;
        a_t_reg    <= t_next[8:0];
        a_base_reg <= base_reg[idx];
        a_line_reg <= line_reg[idx];
        a_pal_reg  <= palette_reg[idx];
        a_fmt_reg  <= format_reg[idx];
        a_size_reg <= size_reg[idx];

        b_none_reg <= a_none_reg;
        b_s_reg    <= a_s_reg;
        b_row_reg  <= row_next;
        b_pal_reg  <= a_pal_reg;
        b_fmt_reg  <= a_fmt_reg;
        b_size_reg <= a_size_reg;

        addr_reg   <= addr_next;
        kind_reg   <= kind_next;
        nib_reg    <= nib_next;
        pal_reg    <= pal_next;
        none_reg   <= none_next;
    end

    assign result_strobe = strobe_reg;
    assign texel_address = addr_reg;
    assign texel_kind    = kind_reg;
    assign nibble_high   = nib_reg;
    assign palette_base  = pal_reg;
    assign no_texel      = none_reg;

endmodule

`default_nettype wire

// ===== rtl/tag_checker.sv =====
`default_nettype none

module tag_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [1:0]         action,
    input wire logic               result_strobe,
    input wire logic [11:0]        texel_address,
    input wire logic [2:0]         texel_kind,
    input wire logic               nibble_high,
    input wire logic [11:0]        palette_base,
    input wire logic               no_texel
);

    // every accepted sample is followed by a result strobe
    a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == tag_pkg::ACT_SAMPLE) |-> ##4 result_strobe)
        else $error("sample transaction produced no result");

    // no result without an earlier accepted sample
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(start && !busy && action == tag_pkg::ACT_SAMPLE, 4))
        else $error("result without a sample transaction");

    // a no-texel result carries zero in every other field
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && no_texel) |->
            (texel_address == '0 && texel_kind == '0 && !nibble_high && palette_base == '0))
        else $error("no-texel result with nonzero fields");

    // nibble select and palette only for indexed kinds
    a_nibble_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && nibble_high) |-> (texel_kind == tag_pkg::KIND_INDEX4))
        else $error("nibble select on a non 4-bit kind");

    a_palette_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && palette_base != '0) |->
            (texel_kind == tag_pkg::KIND_INDEX4 || texel_kind == tag_pkg::KIND_INDEX8))
        else $error("palette base on a non-indexed kind");

endmodule

bind texel_address_generator_core tag_checker u_tag_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // action code the block ignores
    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam int TILES = tag_pkg::TILE_COUNT_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BATCH_ITEMS = 350;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] cmd;
        logic [2:0]  tile;
        logic [31:0] s;
        logic [31:0] t;
    } request_t;

    typedef struct packed {
        logic [11:0] addr;
        logic [2:0]  kind;
        logic        nib;
        logic [11:0] pal;
        logic        none;
    } texel_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         action = '0;
    logic [63:0]        command_word = '0;
    logic [2:0]         tile_index = '0;
    logic signed [31:0] s_coord = '0;
    logic signed [31:0] t_coord = '0;
    logic               result_strobe;
    logic [11:0]        texel_address;
    logic [2:0]         texel_kind;
    logic               nibble_high;
    logic [11:0]        palette_base;
    logic               no_texel;

    // tile table as the testbench sees it
    logic [8:0]  tbl_base    [TILES];
    logic [9:0]  tbl_line    [TILES];
    logic [3:0]  tbl_palette [TILES];
    logic [2:0]  tbl_format  [TILES];
    logic [1:0]  tbl_size    [TILES];
    logic [3:0]  tbl_mask_s  [TILES];
    logic [3:0]  tbl_mask_t  [TILES];
    logic [11:0] tbl_org_s   [TILES];
    logic [11:0] tbl_org_t   [TILES];

    request_t      request_queue [$];
    texel_result_t expected_texels [$];
    request_t      next_req;
    texel_result_t got_texel;
    texel_result_t want_texel;
    logic          req_taken = 1'b0;
    int            idle_pct = 0;
    int            error_count = 0;
    int            idle_cycles = 0;
    int            phase_idle [4] = '{0, 67, 0, 32};
    logic [2:0]    ct;

    texel_address_generator_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .command_word  (command_word),
        .tile_index    (tile_index),
        .s_coord       (s_coord),
        .t_coord       (t_coord),
        .result_strobe (result_strobe),
        .texel_address (texel_address),
        .texel_kind    (texel_kind),
        .nibble_high   (nibble_high),
        .palette_base  (palette_base),
        .no_texel      (no_texel)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // expected sample result from the current tile table
    function automatic texel_result_t predict_texel(input logic [2:0] ti,
                                                    input logic [31:0] s_raw,
                                                    input logic [31:0] t_raw);
        texel_result_t r;
        logic [31:0] s;
        logic [31:0] t;
        logic [31:0] row;
        r = '0;
        if (32'(ti) >= TILES)
        begin
            r.none = 1'b1;
            return r;
        end
        // drop the fraction, keeping the sign
        s = $signed(s_raw) >>> 10;
        t = $signed(t_raw) >>> 10;
        s = s - 32'(tbl_org_s[ti] >> 2);
        t = t - 32'(tbl_org_t[ti] >> 2);
        if (tbl_mask_s[ti] != 4'd0)
            s = s & ((32'd1 << tbl_mask_s[ti]) - 32'd1);
        if (tbl_mask_t[ti] != 4'd0)
            t = t & ((32'd1 << tbl_mask_t[ti]) - 32'd1);
        row = 32'(tbl_base[ti]) * 32'd8 + t * 32'(tbl_line[ti]) * 32'd8;
        case (tbl_size[ti])
            tag_pkg::SIZE_16:
            begin
                r.kind = tag_pkg::KIND_16;
                r.addr = 12'(row + s * 32'd2) & tag_pkg::ADDR_MASK_HALF;
            end
            tag_pkg::SIZE_32:
            begin
                r.kind = tag_pkg::KIND_32;
                r.addr = 12'(row + s * 32'd4) & tag_pkg::ADDR_MASK_WORD;
            end
            tag_pkg::SIZE_8:
            begin
                r.addr = 12'(row + s);
                if (tbl_format[ti] == tag_pkg::FMT_INDEX)
                begin
                    r.kind = tag_pkg::KIND_INDEX8;
                    r.pal = 12'((tag_pkg::PALETTE_AREA * 8) & 'hfff);
                end
                else
                    r.kind = tag_pkg::KIND_INTENS;
            end
            default:
            begin
                // 4-bit texels only exist as color index
                if (tbl_format[ti] == tag_pkg::FMT_INDEX)
                begin
                    r.kind = tag_pkg::KIND_INDEX4;
                    r.addr = 12'(row + (s >> 1));
                    r.nib = s[0];
                    r.pal = 12'((tag_pkg::PALETTE_AREA + 32'(tbl_palette[ti]) * 16) * 8);
                end
                else
                    r.none = 1'b1;
            end
        endcase
        return r;
    endfunction

    // set-tile command word, unused bits random
    function automatic logic [63:0] tile_cmd(input logic [2:0] tl, input logic [8:0] base,
                                             input logic [8:0] line, input logic [3:0] pal,
                                             input logic [2:0] fmt, input logic [1:0] size,
                                             input logic [3:0] ms, input logic [3:0] mt);
        logic [63:0] c;
        c = {$urandom, $urandom};
        c[26:24] = tl;
        c[40:32] = base;
        c[49:41] = line;
        c[23:20] = pal;
        c[55:53] = fmt;
        c[52:51] = size;
        c[17:14] = mt;
        c[7:4] = ms;
        return c;
    endfunction

    // set-tile-size command word, unused bits random
    function automatic logic [63:0] size_cmd(input logic [2:0] tl, input logic [11:0] os,
                                             input logic [11:0] ot);
        logic [63:0] c;
        c = {$urandom, $urandom};
        c[26:24] = tl;
        c[55:44] = os;
        c[43:32] = ot;
        return c;
    endfunction

    // coordinate a few texels around the tile origin, random fraction
    function automatic logic [31:0] near_origin(input logic [11:0] org);
        logic [31:0] w;
        w = 32'(org >> 2) + 32'($urandom_range(0, 40)) - 32'd8;
        return (w << 10) | 32'($urandom_range(0, 1023));
    endfunction

    task automatic push_req(input logic [1:0] act, input logic [63:0] cmd,
                            input logic [2:0] tl, input logic [31:0] s,
                            input logic [31:0] t);
        request_t r;
        r.action = act;
        r.cmd = cmd;
        r.tile = tl;
        r.s = s;
        r.t = t;
        request_queue.insert(request_queue.size(), r);
    endtask

    // mostly set-tile / set-size / sample runs, the rest noise
    task automatic add_random_batch(input int n);
        int count;
        int nsamp;
        logic [2:0] tl;
        logic [2:0] fmt;
        logic [8:0] line;
        logic [11:0] os;
        logic [11:0] ot;
        logic [1:0] act;
        count = 0;
        while (count < n)
        begin
            if ($urandom_range(99) < 80)
            begin
                tl = 3'($urandom_range(7));
                fmt = ($urandom_range(1) != 0) ? tag_pkg::FMT_INDEX : 3'($urandom_range(7));
                line = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(1, 64));
                push_req(tag_pkg::ACT_SET_TILE,
                         tile_cmd(tl, 9'($urandom), line, 4'($urandom), fmt, 2'($urandom),
                                  ($urandom_range(1) != 0) ? 4'd0 : 4'($urandom_range(1, 15)),
                                  ($urandom_range(1) != 0) ? 4'd0 : 4'($urandom_range(1, 15))),
                         3'($urandom), $urandom, $urandom);
                count++;
                os = '0;
                ot = '0;
                if ($urandom_range(9) < 7)
                begin
                    os = 12'($urandom);
                    ot = 12'($urandom);
                    push_req(tag_pkg::ACT_SET_SIZE, size_cmd(tl, os, ot), 3'($urandom),
                             $urandom, $urandom);
                    count++;
                end
                nsamp = $urandom_range(2, 8);
                repeat (nsamp)
                begin
                    if ($urandom_range(9) < 8)
                        push_req(tag_pkg::ACT_SAMPLE, {$urandom, $urandom},
                                 ($urandom_range(9) == 0) ? 3'($urandom) : tl,
                                 near_origin(os), near_origin(ot));
                    else
                        push_req(tag_pkg::ACT_SAMPLE, {$urandom, $urandom}, 3'($urandom),
                                 $urandom, $urandom);
                    count++;
                end
            end
            else
            begin
                act = 2'($urandom);
                push_req(act, {$urandom, $urandom}, 3'($urandom), $urandom, $urandom);
                if (act != ACT_IGNORED)
                    count++;
            end
        end
    endtask

    // driver: new transaction on the falling edge once the last one was taken
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || req_taken)
        begin
            if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                next_req = request_queue.pop_front();
                start <= 1'b1;
                action <= next_req.action;
                command_word <= next_req.cmd;
                tile_index <= next_req.tile;
                s_coord <= next_req.s;
                t_coord <= next_req.t;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check results, then apply the accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken <= 1'b0;
            for (int i = 0; i < TILES; i++)
            begin
                tbl_base[i] = '0;
                tbl_line[i] = '0;
                tbl_palette[i] = '0;
                tbl_format[i] = '0;
                tbl_size[i] = '0;
                tbl_mask_s[i] = '0;
                tbl_mask_t[i] = '0;
                tbl_org_s[i] = '0;
                tbl_org_t[i] = '0;
            end
        end
        else
        begin
            req_taken <= start && !busy;
            if (result_strobe)
            begin
                got_texel = {texel_address, texel_kind, nibble_high, palette_base, no_texel};
                if (expected_texels.size() == 0)
                begin
                    if (error_count < 10)
                        $display("unexpected result: addr %h kind %0d nib %0d pal %h none %0d",
                                 texel_address, texel_kind, nibble_high, palette_base,
                                 no_texel);
                    error_count++;
                end
                else
                begin
                    want_texel = expected_texels.pop_front();
                    if (got_texel !== want_texel)
                    begin
                        if (error_count < 10)
                        begin
                            $write("mismatch (exp/got): addr %h/%h kind %0d/%0d ",
                                   want_texel.addr, got_texel.addr, want_texel.kind,
                                   got_texel.kind);
                            $display("nib %0d/%0d pal %h/%h none %0d/%0d",
                                     want_texel.nib, got_texel.nib, want_texel.pal,
                                     got_texel.pal, want_texel.none, got_texel.none);
                        end
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                ct = command_word[26:24];
                case (action)
                    tag_pkg::ACT_SET_TILE:
                    begin
                        if (32'(ct) < TILES)
                        begin
                            tbl_base[ct] = command_word[40:32];
                            tbl_size[ct] = command_word[52:51];
                            // 32-bit tiles count lines in half units
                            tbl_line[ct] = (command_word[52:51] == tag_pkg::SIZE_32) ?
                                           {command_word[49:41], 1'b0} :
                                           {1'b0, command_word[49:41]};
                            tbl_palette[ct] = command_word[23:20];
                            tbl_format[ct] = command_word[55:53];
                            tbl_mask_t[ct] = command_word[17:14];
                            tbl_mask_s[ct] = command_word[7:4];
                        end
                    end
                    tag_pkg::ACT_SET_SIZE:
                    begin
                        if (32'(ct) < TILES)
                        begin
                            tbl_org_s[ct] = command_word[55:44];
                            tbl_org_t[ct] = command_word[43:32];
                        end
                    end
                    tag_pkg::ACT_SAMPLE:
                        expected_texels.insert(expected_texels.size(),
                                               predict_texel(tile_index, s_coord, t_coord));
                    default:
                        ;
                endcase
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** texel_address_generator_core: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        // sample before any tile is set: 4-bit, non-index, so no texel
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd0, 32'h0000_0000, 32'h0000_0000);
        // 16-bit tile, coordinate extremes
        push_req(tag_pkg::ACT_SET_TILE,
                 tile_cmd(3'd0, 9'h000, 9'h001, 4'h0, 3'd0, tag_pkg::SIZE_16, 4'd0, 4'd0),
                 3'd0, '0, '0);
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd0, 32'h0000_0000, 32'h0000_0000);
        push_req(tag_pkg::ACT_SAMPLE, '1, 3'd0, 32'h7fff_ffff, 32'h8000_0000);
        // all ones: tile 7, 32-bit with doubled line, full masks
        push_req(tag_pkg::ACT_SET_TILE, '1, 3'd7, '1, '1);
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd7, 32'hffff_ffff, 32'hffff_ffff);
        push_req(tag_pkg::ACT_SET_SIZE, '1, 3'd7, '0, '0);
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd7, 32'h0000_0000, 32'h0000_0000);
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd7, 32'h8000_0000, 32'h7fff_ffff);
        // 8-bit color index and 8-bit intensity
        push_req(tag_pkg::ACT_SET_TILE,
                 tile_cmd(3'd2, 9'h040, 9'h004, 4'h5, tag_pkg::FMT_INDEX, tag_pkg::SIZE_8,
                          4'd0, 4'd0), 3'd0, '0, '0);
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd2, 32'h0000_0c00, 32'h0000_0400);
        push_req(tag_pkg::ACT_SET_TILE,
                 tile_cmd(3'd3, 9'h010, 9'h008, 4'h9, 3'd4, tag_pkg::SIZE_8, 4'd5, 4'd1),
                 3'd0, '0, '0);
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd3, 32'hffff_f7ff, 32'h0000_0bff);
        // 4-bit index, odd and even s, negative s
        push_req(tag_pkg::ACT_SET_TILE,
                 tile_cmd(3'd4, 9'h1ff, 9'h002, 4'hf, tag_pkg::FMT_INDEX, tag_pkg::SIZE_4,
                          4'd3, 4'd2), 3'd0, '0, '0);
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd4, 32'h0000_1400, 32'h0000_0c00);
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd4, 32'hffff_f800, 32'hffff_fc00);
        push_req(tag_pkg::ACT_SET_SIZE, size_cmd(3'd4, 12'h01c, 12'h008), 3'd0, '0, '0);
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd4, 32'h0000_1c00, 32'h0000_0800);
        // 4-bit with a non-index format gives no texel
        push_req(tag_pkg::ACT_SET_TILE,
                 tile_cmd(3'd5, 9'h0aa, 9'h003, 4'h3, 3'd3, tag_pkg::SIZE_4, 4'd0, 4'd0),
                 3'd0, '0, '0);
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd5, 32'h0000_0400, 32'h0000_0400);
        // unused action is dropped
        push_req(ACT_IGNORED, '1, 3'd5, '1, '1);
        // widest line and base on a 32-bit tile
        push_req(tag_pkg::ACT_SET_TILE,
                 tile_cmd(3'd6, 9'h1ff, 9'h1ff, 4'h0, 3'd0, tag_pkg::SIZE_32, 4'd0, 4'd0),
                 3'd0, '0, '0);
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd6, 32'h3fff_fc00, 32'hc000_0000);
        push_req(tag_pkg::ACT_SET_SIZE, '0, 3'd0, '0, '0);
        push_req(tag_pkg::ACT_SAMPLE, '0, 3'd7, 32'h0000_0000, 32'h0000_0000);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // phases: no gaps, heavy sender gaps, no gaps, light gaps
        for (int p = 0; p < 4; p++)
        begin
            while (request_queue.size() != 0)
                @(posedge clk);
            idle_pct = phase_idle[p];
            add_random_batch(BATCH_ITEMS);
        end

        while (request_queue.size() != 0 || start)
            @(posedge clk);
        while (expected_texels.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("** texel_address_generator_core: PASSED **");
        else
            $display("** texel_address_generator_core: FAILED **");
        $finish;
    end

endmodule
